>>> hw/rtl/assert_macros.svh
// Assertion shorthands; clk and rst are taken from the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/ctdih_pkg.sv
package ctdih_pkg;

  localparam int MAX_CARDS = 16;
  localparam int ID_BYTES  = 4;

  localparam int CNT_W  = $clog2(MAX_CARDS + 1);
  localparam int STEP_W = (MAX_CARDS > 1) ? $clog2(MAX_CARDS) : 1;
  localparam int BYTE_W = $clog2(ID_BYTES + 1);

  localparam logic [15:0] HASH_SEED = 16'h1357;
  localparam logic [31:0] ID_MASK   = (ID_BYTES >= 4) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << (8 * ID_BYTES)) - 64'd1);

  typedef enum logic [1:0] {
    ST_NEW   = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_CLEAR = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_HASH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic init;
    logic step;
  } hash_ctl_t;

  // Byte j of an ID, first byte in the top bits; bytes above bit 31 read zero.
  function automatic logic [7:0] id_byte(logic [31:0] id, logic [BYTE_W-1:0] j);
    int sh;
    sh = 8 * (ID_BYTES - 1 - int'(j));
    if (sh >= 0 && sh < 32) begin
      return 8'(id >> sh);
    end
    return 8'd0;
  endfunction

endpackage

>>> hw/rtl/ctdih_in_if.sv
interface ctdih_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] card_id;
  logic [7:0]  warehouse;

  modport source(output valid, func, card_id, warehouse, input ready);
  modport sink(input valid, func, card_id, warehouse, output ready);
endinterface

>>> hw/rtl/ctdih_out_if.sv
interface ctdih_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [1:0]  status;
  logic [4:0]  entry_count;
  logic [15:0] trip_hash;
  logic [7:0]  current_location;

  modport source(output valid, accepted, status, entry_count, trip_hash,
                 current_location, input ready);
  modport sink(input valid, accepted, status, entry_count, trip_hash,
               current_location, output ready);
endinterface

>>> hw/rtl/ctdih_cell.sv
module ctdih_cell import ctdih_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cell_ctl_t   ctl,
  input  logic        valid,
  input  logic [31:0] key,
  input  logic [31:0] load_id,
  input  logic [1:0]  load_code,
  input  logic [31:0] nbr_id,
  input  logic [1:0]  nbr_code,
  output logic [31:0] id,
  output logic [1:0]  code,
  output logic        match
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      id   <= '0;
      code <= '0;
    end else if (ctl.load) begin
      id   <= load_id;
      code <= load_code;
    end else if (ctl.shift) begin
      id   <= nbr_id;
      code <= nbr_code;
    end
  end

  assign match = valid && (id == key);

endmodule

>>> hw/rtl/ctdih_hash.sv
module ctdih_hash import ctdih_pkg::*; (
  input  logic        clk,
  input  hash_ctl_t   ctl,
  input  logic [15:0] x,
  output logic [15:0] h
);

  logic [15:0] h_next;

  // h*31 + x, mod 2^16
  assign h_next = 16'({h, 5'b0} - {5'b0, h} + {5'b0, x});

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      h <= HASH_SEED;
    end else if (ctl.step) begin
      h <= h_next;
    end
  end

endmodule

>>> hw/rtl/card_table_dedup_insert_hash.sv
// Channel | Dir | Payload                                                    | Flow
// req     | in  | func, card_id, warehouse                                   | valid/ready
// rsp     | out | accepted, status, entry_count, trip_hash, current_location | valid/ready
//
// One item at a time: accept, table check, hash walk, then result load.
// The walk rotates the cell row MAX_CARDS places; a stored entry holds the row
// for ID_BYTES+1 hash steps, and an empty slot passes with no hash step.
// Reset (rst, synchronous) empties the table and sets current_location to 1.
// A waiting result does not block the input; a stalled result holds S_DONE.
module card_table_dedup_insert_hash import ctdih_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ctdih_in_if.sink   req,
  ctdih_out_if.source rsp
);

`include "assert_macros.svh"

  state_t state, state_next;

  // latched request
  logic        req_func;
  logic [31:0] req_id;
  logic [7:0]  req_wh;

  logic [CNT_W-1:0]  count;
  logic [7:0]        cur_loc;
  status_t           res_status;
  logic              res_accepted;
  logic [STEP_W-1:0] step;
  logic [BYTE_W-1:0] byte_idx;

  // result register
  logic        out_valid;
  logic        out_accepted;
  status_t     out_status;
  logic [4:0]  out_count;
  logic [15:0] out_hash;
  logic [7:0]  out_loc;

  // cell row
  cell_ctl_t   cell_ctl [MAX_CARDS];
  logic [31:0] cell_id   [MAX_CARDS];
  logic [1:0]  cell_code [MAX_CARDS];
  logic [MAX_CARDS-1:0] cell_match;
  logic [1:0]  new_code;

  hash_ctl_t   hctl;
  logic [15:0] hx;
  logic [15:0] h;
  logic [7:0]  packed_byte;

  logic full, hit, do_add, in_entry, last_byte, adv, last_step, out_free;

  // ---- cell row: cell k hands its contents to cell k-1, cell 0 wraps to the end
  for (genvar k = 0; k < MAX_CARDS; k++) begin : g_cell
    localparam int NB = (k + 1 == MAX_CARDS) ? 0 : k + 1;
    ctdih_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (cell_ctl[k]),
      .valid     (count > CNT_W'(k)),
      .key       (req_id),
      .load_id   (req_id),
      .load_code (new_code),
      .nbr_id    (cell_id[NB]),
      .nbr_code  (cell_code[NB]),
      .id        (cell_id[k]),
      .code      (cell_code[k]),
      .match     (cell_match[k])
    );
  end

  ctdih_hash u_hash (
    .clk (clk),
    .ctl (hctl),
    .x   (hx),
    .h   (h)
  );

  // ---- decisions
  assign full      = (count >= CNT_W'(MAX_CARDS));
  assign hit       = |cell_match;
  assign do_add    = !req_func && !full && !hit;
  assign new_code  = (req_wh >= 8'd1 && req_wh <= 8'd4) ? 2'(req_wh - 8'd1) : 2'd0;
  assign in_entry  = (CNT_W'(step) < count);
  assign last_byte = (byte_idx == BYTE_W'(ID_BYTES));
  assign adv       = !in_entry || last_byte;
  assign last_step = (step == STEP_W'(MAX_CARDS - 1));
  assign out_free  = !out_valid || rsp.ready;

  // Packed code byte of the group holding the head entry. At walk step i, cell c
  // holds entry i+c (mod MAX_CARDS), so group members sit in the first few cells
  // or wrapped around at the tail end of the row.
  always_comb begin
    int e;
    int ci;
    logic [1:0] r;
    packed_byte = 8'd0;
    r = 2'(step);
    for (int rr = 0; rr < 4; rr++) begin
      for (int kk = 0; kk < 4; kk++) begin
        e  = int'(step) - rr + kk;
        ci = kk - rr;
        if (ci < 0) begin
          ci = ci + MAX_CARDS;
        end
        if (r == 2'(rr) && e < MAX_CARDS && ci >= 0 && ci < MAX_CARDS) begin
          packed_byte = packed_byte | (8'(cell_code[ci]) << (2 * kk));
        end
      end
    end
  end

  // ---- next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req.valid) state_next = S_CHECK;
      S_CHECK: state_next = S_HASH;
      S_HASH:  if (adv && last_step) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // ---- control outputs
  always_comb begin
    req.ready = (state == S_IDLE);
    hctl.init = (state == S_CHECK);
    hctl.step = (state == S_HASH) && in_entry;
    hx        = last_byte ? (16'(packed_byte) + 16'(step))
                          : 16'(id_byte(cell_id[0], byte_idx));
    for (int k = 0; k < MAX_CARDS; k++) begin
      cell_ctl[k].clear = (state == S_CHECK) && req_func;
      cell_ctl[k].load  = (state == S_CHECK) && do_add && (count == CNT_W'(k));
      cell_ctl[k].shift = (state == S_HASH) && adv;
    end
  end

  // ---- control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cur_loc   <= 8'd1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CHECK) begin
        if (req_func) begin
          count <= '0;
        end else if (do_add) begin
          count   <= count + CNT_W'(1);
          cur_loc <= req_wh;
        end
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---- payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      req_func <= req.func;
      req_id   <= req.card_id & ID_MASK;
      req_wh   <= req.warehouse;
    end
    if (state == S_CHECK) begin
      step     <= '0;
      byte_idx <= '0;
      res_accepted <= do_add;
      priority if (req_func) res_status <= ST_CLEAR;
      else if (full)         res_status <= ST_FULL;
      else if (hit)          res_status <= ST_DUP;
      else                   res_status <= ST_NEW;
    end else if (state == S_HASH) begin
      if (adv) begin
        step     <= step + STEP_W'(1);
        byte_idx <= '0;
      end else begin
        byte_idx <= byte_idx + BYTE_W'(1);
      end
    end
    if (state == S_DONE && out_free) begin
      out_accepted <= res_accepted;
      out_status   <= res_status;
      out_count    <= 5'(count);
      out_hash     <= (count == '0) ? 16'd0 : h;
      out_loc      <= cur_loc;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.accepted         = out_accepted;
  assign rsp.status           = out_status;
  assign rsp.entry_count      = out_count;
  assign rsp.trip_hash        = out_hash;
  assign rsp.current_location = out_loc;

  // ---- checks
  `ASSERT_IMPL(a_count_bound, 1'b1, count <= CNT_W'(MAX_CARDS))
  `ASSERT_NEXT(a_accept_check, req.valid && req.ready, state == S_CHECK)
  `ASSERT_IMPL(a_accepted_new, rsp.valid, rsp.accepted == (out_status == ST_NEW))
  `ASSERT_IMPL(a_clear_empty, rsp.valid && out_status == ST_CLEAR, {out_count, out_hash} == '0)

endmodule
